// ===== rtl/pmm_pkg.sv =====
// Package for the power mode manager: word and register types, codes,
// reset values and limits. No dependencies.

package pmm_pkg;

   localparam int DEFAULT_WAKE_SOURCES = 8;
   localparam int REQUIRED_SOURCES     = 3;
   localparam int REQUIRED_ATTEMPTS    = 100;
   localparam int FULL_PERCENT         = 100;
   localparam int CSR_ADDR_W           = 5;
   localparam int CSR_DATA_W           = 32;

   localparam logic [2:0] FUNC_ACTIVITY = 3'd0;
   localparam logic [2:0] FUNC_BATTERY  = 3'd1;
   localparam logic [2:0] FUNC_WIFI     = 3'd2;
   localparam logic [2:0] FUNC_WAKE     = 3'd3;
   localparam logic [2:0] FUNC_QUERY    = 3'd4;

   localparam logic [3:0] MODE_ACTIVE   = 4'd0;
   localparam logic [3:0] MODE_DIM      = 4'd1;
   localparam logic [3:0] MODE_GLANCE   = 4'd2;
   localparam logic [3:0] MODE_OFF      = 4'd3;
   localparam logic [3:0] MODE_THERMAL  = 4'd4;
   localparam logic [3:0] MODE_CHARGING = 4'd5;
   localparam logic [3:0] MODE_CRITICAL = 4'd6;
   localparam logic [3:0] MODE_LOW      = 4'd7;
   localparam logic [3:0] MODE_SAVER    = 4'd8;

   localparam logic [2:0] REG_IDLE_TO_DIM    = 3'd0;
   localparam logic [2:0] REG_DIM_TO_GLANCE  = 3'd1;
   localparam logic [2:0] REG_GLANCE_TO_OFF  = 3'd2;
   localparam logic [2:0] REG_CRITICAL       = 3'd3;
   localparam logic [2:0] REG_LOW            = 3'd4;
   localparam logic [2:0] REG_SAVER          = 3'd5;
   localparam logic [2:0] REG_MIN_TEMP       = 3'd6;
   localparam logic [2:0] REG_MAX_TEMP       = 3'd7;

   localparam logic [31:0] RESET_IDLE_TO_DIM   = 32'd30000;
   localparam logic [31:0] RESET_DIM_TO_GLANCE = 32'd10000;
   localparam logic [31:0] RESET_GLANCE_TO_OFF = 32'd20000;
   localparam logic [6:0]  RESET_CRITICAL      = 7'd5;
   localparam logic [6:0]  RESET_LOW           = 7'd15;
   localparam logic [6:0]  RESET_SAVER         = 7'd30;
   localparam logic signed [7:0] RESET_MIN_TEMP = 8'sd0;
   localparam logic signed [7:0] RESET_MAX_TEMP = 8'sd45;

   typedef struct packed {
      logic [2:0]         func;
      logic [31:0]        now_ms;
      logic               report_valid;
      logic signed [7:0]  report_temperature;
      logic               report_charging;
      logic               report_vbus;
      logic signed [7:0]  report_percent;
      logic               wifi_active;
      logic               heavy_session;
      logic [3:0]         wake_source;
      logic [15:0]        wake_attempts;
      logic [15:0]        wake_successes;
   } req_word_type;

   typedef struct packed {
      logic [3:0] mode;
      logic       wifi_allowed;
      logic       sleep_gate_open;
      logic       source_ignored;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0]       dim_after_ms;
      logic [31:0]       glance_after_ms;
      logic [31:0]       off_after_ms;
      logic [32:0]       glance_limit;
      logic [33:0]       off_limit;
      logic [6:0]        critical_percent;
      logic [6:0]        low_percent;
      logic [6:0]        saver_percent;
      logic signed [7:0] min_safe_temperature;
      logic signed [7:0] max_safe_temperature;
   } cfg_type;

   typedef struct packed {
      logic [31:0]       last_activity_time;
      logic              battery_valid;
      logic signed [7:0] battery_temperature;
      logic              battery_charging;
      logic              battery_vbus;
      logic signed [7:0] battery_level;
      logic              wifi_session;
   } state_type;

endpackage

// ===== rtl/pmm_req_if.sv =====
// Request channel of the power mode manager: valid, ready and one event word.
// Depends on pmm_pkg.

interface pmm_req_if;
   import pmm_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source(output valid, output word, input ready);
   modport sink(input valid, input word, output ready);
endinterface

// ===== rtl/pmm_rsp_if.sv =====
// Response channel of the power mode manager: valid, ready and one result word.
// Depends on pmm_pkg.

interface pmm_rsp_if;
   import pmm_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source(output valid, output word, input ready);
   modport sink(input valid, input word, output ready);
endinterface

// ===== rtl/pmm_csr.sv =====
// Configuration registers of the power mode manager behind an APB-style port,
// with the idle timer limits kept as running sums. Depends on pmm_pkg.

module pmm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pmm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pmm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pmm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output pmm_pkg::cfg_type                 cfg
);
   import pmm_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_IDLE_TO_DIM:   cfg_in.dim_after_ms         = pwdata;
            REG_DIM_TO_GLANCE: cfg_in.glance_after_ms      = pwdata;
            REG_GLANCE_TO_OFF: cfg_in.off_after_ms         = pwdata;
            REG_CRITICAL:      cfg_in.critical_percent     = pwdata[6:0];
            REG_LOW:           cfg_in.low_percent          = pwdata[6:0];
            REG_SAVER:         cfg_in.saver_percent        = pwdata[6:0];
            REG_MIN_TEMP:      cfg_in.min_safe_temperature = $signed(pwdata[7:0]);
            REG_MAX_TEMP:      cfg_in.max_safe_temperature = $signed(pwdata[7:0]);
            default: ;
         endcase
      end
      cfg_in.glance_limit = {1'b0, cfg_in.dim_after_ms}
                          + {1'b0, cfg_in.glance_after_ms};
      cfg_in.off_limit    = {2'b00, cfg_in.dim_after_ms}
                          + {2'b00, cfg_in.glance_after_ms}
                          + {2'b00, cfg_in.off_after_ms};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_after_ms         <= RESET_IDLE_TO_DIM;
         cfg_ff.glance_after_ms      <= RESET_DIM_TO_GLANCE;
         cfg_ff.off_after_ms         <= RESET_GLANCE_TO_OFF;
         cfg_ff.glance_limit         <= {1'b0, RESET_IDLE_TO_DIM}
                                      + {1'b0, RESET_DIM_TO_GLANCE};
         cfg_ff.off_limit            <= {2'b00, RESET_IDLE_TO_DIM}
                                      + {2'b00, RESET_DIM_TO_GLANCE}
                                      + {2'b00, RESET_GLANCE_TO_OFF};
         cfg_ff.critical_percent     <= RESET_CRITICAL;
         cfg_ff.low_percent          <= RESET_LOW;
         cfg_ff.saver_percent        <= RESET_SAVER;
         cfg_ff.min_safe_temperature <= RESET_MIN_TEMP;
         cfg_ff.max_safe_temperature <= RESET_MAX_TEMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_IDLE_TO_DIM:   prdata = cfg_ff.dim_after_ms;
         REG_DIM_TO_GLANCE: prdata = cfg_ff.glance_after_ms;
         REG_GLANCE_TO_OFF: prdata = cfg_ff.off_after_ms;
         REG_CRITICAL:      prdata = {25'd0, cfg_ff.critical_percent};
         REG_LOW:           prdata = {25'd0, cfg_ff.low_percent};
         REG_SAVER:         prdata = {25'd0, cfg_ff.saver_percent};
         REG_MIN_TEMP:      prdata = {24'd0, cfg_ff.min_safe_temperature};
         REG_MAX_TEMP:      prdata = {24'd0, cfg_ff.max_safe_temperature};
         default: ;
      endcase
   end

endmodule

// ===== rtl/pmm_state.sv =====
// Event state of the power mode manager: activity time, battery report, wifi
// flag and wake-source counts, with the next state after the staged event.
// Depends on pmm_pkg.

module pmm_state #(
   parameter int WAKE_SOURCES = pmm_pkg::DEFAULT_WAKE_SOURCES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  pmm_pkg::req_word_type                   item,
   output pmm_pkg::state_type                      next_state,
   output logic [pmm_pkg::REQUIRED_SOURCES-1:0]    verified,
   output logic                                    source_ignored
);
   import pmm_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   logic [15:0] attempts_ff  [WAKE_SOURCES];
   logic [15:0] successes_ff [WAKE_SOURCES];
   logic [15:0] clamped;
   logic        wake_wr;

   assign source_ignored = (item.func == FUNC_WAKE)
                        && ({1'b0, item.wake_source} >= 5'(WAKE_SOURCES));
   assign wake_wr = advance && (item.func == FUNC_WAKE) && !source_ignored;
   assign clamped = (item.wake_successes > item.wake_attempts)
                  ? item.wake_attempts : item.wake_successes;

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         case (item.func)
            FUNC_ACTIVITY: state_in.last_activity_time = item.now_ms;
            FUNC_BATTERY: begin
               state_in.battery_valid       = item.report_valid;
               state_in.battery_temperature = item.report_temperature;
               state_in.battery_charging    = item.report_charging;
               state_in.battery_vbus        = item.report_vbus;
               state_in.battery_level       = item.report_percent;
            end
            FUNC_WIFI: state_in.wifi_session = item.wifi_active;
            default: ;
         endcase
      end
   end

   assign next_state = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAKE_SOURCES; i++) begin
            attempts_ff[i]  <= '0;
            successes_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < WAKE_SOURCES; i++) begin
            if (wake_wr && (item.wake_source == 4'(i))) begin
               attempts_ff[i]  <= item.wake_attempts;
               successes_ff[i] <= clamped;
            end
         end
      end
   end

   for (genvar k = 0; k < REQUIRED_SOURCES; k++) begin : g_required
      if (k < WAKE_SOURCES) begin : g_present
         logic        hit;
         logic [15:0] att_next;
         logic [15:0] suc_next;
         assign hit      = wake_wr && (item.wake_source == 4'(k));
         assign att_next = hit ? item.wake_attempts : attempts_ff[k];
         assign suc_next = hit ? clamped : successes_ff[k];
         assign verified[k] = (att_next >= 16'(REQUIRED_ATTEMPTS))
                           && (suc_next == att_next);
      end else begin : g_absent
         assign verified[k] = 1'b0;
      end
   end

endmodule

// ===== rtl/pmm_eval.sv =====
// Result logic of the power mode manager: mode with battery priority over the
// idle timer, wifi permission and light-sleep gate. Depends on pmm_pkg.

module pmm_eval (
   input  pmm_pkg::cfg_type                        cfg,
   input  pmm_pkg::state_type                      state,
   input  logic [31:0]                             elapsed,
   input  logic                                    heavy_session,
   input  logic [pmm_pkg::REQUIRED_SOURCES-1:0]    verified,
   input  logic                                    source_ignored,
   output pmm_pkg::rsp_word_type                   result
);
   import pmm_pkg::*;

   logic [3:0]        idle_mode;
   logic signed [8:0] level;
   logic              at_critical;
   logic              at_low;
   logic              at_saver;
   logic              too_hot_cold;
   logic              powered;
   logic              level_known;

   assign level        = {state.battery_level[7], state.battery_level};
   assign at_critical  = level <= $signed({2'b00, cfg.critical_percent});
   assign at_low       = level <= $signed({2'b00, cfg.low_percent});
   assign at_saver     = level <= $signed({2'b00, cfg.saver_percent});
   assign too_hot_cold = (state.battery_temperature < cfg.min_safe_temperature)
                      || (state.battery_temperature > cfg.max_safe_temperature);
   assign powered      = state.battery_charging || state.battery_vbus;
   assign level_known  = state.battery_valid && !level[8]
                      && (level <= 9'sd100);

   always_comb begin
      if (elapsed < cfg.dim_after_ms) begin
         idle_mode = MODE_ACTIVE;
      end else if ({1'b0, elapsed} < cfg.glance_limit) begin
         idle_mode = MODE_DIM;
      end else if ({2'b00, elapsed} < cfg.off_limit) begin
         idle_mode = MODE_GLANCE;
      end else begin
         idle_mode = MODE_OFF;
      end
   end

   always_comb begin
      result.source_ignored  = source_ignored;
      result.sleep_gate_open = !state.wifi_session && (&verified);

      if (!state.battery_valid) begin
         result.mode = idle_mode;
      end else if (too_hot_cold) begin
         result.mode = MODE_THERMAL;
      end else if (powered) begin
         result.mode = MODE_CHARGING;
      end else if (at_critical) begin
         result.mode = MODE_CRITICAL;
      end else if (at_low) begin
         result.mode = MODE_LOW;
      end else if (at_saver) begin
         result.mode = MODE_SAVER;
      end else begin
         result.mode = idle_mode;
      end

      if (!level_known) begin
         result.wifi_allowed = !heavy_session;
      end else if (at_critical) begin
         result.wifi_allowed = 1'b0;
      end else if (powered) begin
         result.wifi_allowed = 1'b1;
      end else begin
         result.wifi_allowed = !heavy_session || !at_low;
      end
   end

endmodule

// ===== rtl/power_mode_manager.sv =====
// Power mode manager top level: input stage, event state, result logic and
// output register. Depends on pmm_pkg, pmm_req_if, pmm_rsp_if, pmm_csr,
// pmm_state and pmm_eval.
//
// Usage:
//   req_chan carries one event word (activity, battery report, wifi flag,
//   wake record or query) with a timestamp; rsp_chan returns one result word
//   per event: power mode, wifi permission, light-sleep gate and a flag for
//   a dropped wake record. Both use valid/ready; a word moves when both are
//   high at a rising clock edge.
//   A request is accepted into the input stage, and its result is registered
//   in the output register as the word leaves the input stage. One word per
//   cycle is sustained while rsp_chan.ready stays high: the input stage and
//   the output register each hold one word, and the event is applied to the
//   state as the word leaves the input stage. Elapsed idle time is taken at
//   acceptance against the state the previous word leaves.
//   When rsp_chan stalls, the output register holds its word, the input stage
//   fills, then req_chan.ready drops; nothing is lost.
//   Synchronous reset empties both stages, clears the event state and wake
//   counts and loads the default thresholds. Write the APB registers only
//   while no word is in flight.

module power_mode_manager #(
   parameter int WAKE_SOURCES = pmm_pkg::DEFAULT_WAKE_SOURCES
) (
   input  logic                             clock,
   input  logic                             reset,
   pmm_req_if.sink                          req_chan,
   pmm_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pmm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pmm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pmm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import pmm_pkg::*;

   cfg_type                     cfg;
   state_type                   next_state;
   logic [REQUIRED_SOURCES-1:0] verified;
   logic                        source_ignored;
   rsp_word_type                result;

   logic                        stage_valid_ff;
   logic                        stage_valid_in;
   req_word_type                stage_word_ff;
   logic [31:0]                 elapsed_ff;
   logic [31:0]                 elapsed_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   rsp_word_type                out_word_ff;
   logic                        advance;
   logic                        accept;

   pmm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pmm_state #(
      .WAKE_SOURCES (WAKE_SOURCES)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (stage_word_ff),
      .next_state     (next_state),
      .verified       (verified),
      .source_ignored (source_ignored)
   );

   pmm_eval u_eval (
      .cfg            (cfg),
      .state          (next_state),
      .elapsed        (elapsed_ff),
      .heavy_session  (stage_word_ff.heavy_session),
      .verified       (verified),
      .source_ignored (source_ignored),
      .result         (result)
   );

   assign advance        = stage_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // activity events restart the idle timer at zero
   assign elapsed_in = (req_chan.word.func == FUNC_ACTIVITY) ? 32'd0
                     : req_chan.word.now_ms - next_state.last_activity_time;

   assign stage_valid_in = accept || (stage_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_word_ff <= req_chan.word;
         elapsed_ff    <= elapsed_in;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word  = out_word_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for power_mode_manager: timestamped events under random flow control and
// APB register settings, with every result word predicted and checked field by field.
// Depends on pmm_pkg, pmm_req_if, pmm_rsp_if and the power_mode_manager RTL.

module testbench;
   import pmm_pkg::*;

   localparam int SOURCES      = DEFAULT_WAKE_SOURCES;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 150;
   localparam int PHASE_WORDS  = 265;
   localparam int PHASES       = 7;
   localparam int DRAIN_CYCLES = 8;

   class mode_tracker;
      logic [31:0]       dim_ms;
      logic [31:0]       glance_ms;
      logic [31:0]       off_ms;
      logic [6:0]        critical_pct;
      logic [6:0]        low_pct;
      logic [6:0]        saver_pct;
      logic signed [7:0] temp_min;
      logic signed [7:0] temp_max;
      logic [31:0]       last_activity;
      logic              bat_valid;
      logic signed [7:0] bat_temp;
      logic              bat_charging;
      logic              bat_vbus;
      logic signed [7:0] bat_level;
      logic              wifi_session;
      logic [15:0]       attempts [SOURCES];
      logic [15:0]       successes [SOURCES];
      rsp_word_type      pending_outcomes [$];
      int                errors;
      int                checked;

      function new();
         dim_ms        = RESET_IDLE_TO_DIM;
         glance_ms     = RESET_DIM_TO_GLANCE;
         off_ms        = RESET_GLANCE_TO_OFF;
         critical_pct  = RESET_CRITICAL;
         low_pct       = RESET_LOW;
         saver_pct     = RESET_SAVER;
         temp_min      = RESET_MIN_TEMP;
         temp_max      = RESET_MAX_TEMP;
         last_activity = '0;
         bat_valid     = 1'b0;
         bat_temp      = '0;
         bat_charging  = 1'b0;
         bat_vbus      = 1'b0;
         bat_level     = '0;
         wifi_session  = 1'b0;
         foreach (attempts[i]) begin
            attempts[i]  = '0;
            successes[i] = '0;
         end
         errors  = 0;
         checked = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_IDLE_TO_DIM:   dim_ms = value;
            REG_DIM_TO_GLANCE: glance_ms = value;
            REG_GLANCE_TO_OFF: off_ms = value;
            REG_CRITICAL:      critical_pct = value[6:0];
            REG_LOW:           low_pct = value[6:0];
            REG_SAVER:         saver_pct = value[6:0];
            REG_MIN_TEMP:      temp_min = value[7:0];
            REG_MAX_TEMP:      temp_max = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [3:0] idle_mode(logic [31:0] now);
         logic [31:0] elapsed;
         elapsed = now - last_activity;
         if (elapsed < dim_ms) return MODE_ACTIVE;
         elapsed -= dim_ms;
         if (elapsed < glance_ms) return MODE_DIM;
         elapsed -= glance_ms;
         if (elapsed < off_ms) return MODE_GLANCE;
         return MODE_OFF;
      endfunction

      function logic [3:0] power_mode(logic [31:0] now);
         int level;
         level = bat_level;
         if (!bat_valid) return idle_mode(now);
         if (bat_temp < temp_min || bat_temp > temp_max) return MODE_THERMAL;
         if (bat_charging || bat_vbus) return MODE_CHARGING;
         if (level <= int'(critical_pct)) return MODE_CRITICAL;
         if (level <= int'(low_pct)) return MODE_LOW;
         if (level <= int'(saver_pct)) return MODE_SAVER;
         return idle_mode(now);
      endfunction

      function logic wifi_permitted(logic high);
         int   level;
         logic known;
         level = bat_level;
         known = bat_valid && level >= 0 && level <= FULL_PERCENT;
         if (!known) return !high;
         if (level <= int'(critical_pct)) return 1'b0;
         if (bat_charging || bat_vbus) return 1'b1;
         return !high || level > int'(low_pct);
      endfunction

      function logic sleep_gate();
         logic open;
         int   i;
         open = !wifi_session;
         for (i = 0; i < REQUIRED_SOURCES; i++) begin
            if (i >= SOURCES) begin
               open = 1'b0;
            end else if (attempts[i] < REQUIRED_ATTEMPTS || successes[i] != attempts[i]) begin
               open = 1'b0;
            end
         end
         return open;
      endfunction

      function void accept_event(req_word_type w);
         rsp_word_type outcome;
         outcome = '0;
         case (w.func)
            FUNC_ACTIVITY: last_activity = w.now_ms;
            FUNC_BATTERY: begin
               bat_valid    = w.report_valid;
               bat_temp     = w.report_temperature;
               bat_charging = w.report_charging;
               bat_vbus     = w.report_vbus;
               bat_level    = w.report_percent;
            end
            FUNC_WIFI: wifi_session = w.wifi_active;
            FUNC_WAKE: begin
               if (int'(w.wake_source) < SOURCES) begin
                  attempts[w.wake_source]  = w.wake_attempts;
                  successes[w.wake_source] = (w.wake_successes > w.wake_attempts) ?
                                             w.wake_attempts : w.wake_successes;
               end else begin
                  outcome.source_ignored = 1'b1;
               end
            end
            default: ;
         endcase
         outcome.mode            = power_mode(w.now_ms);
         outcome.wifi_allowed    = wifi_permitted(w.heavy_session);
         outcome.sleep_gate_open = sleep_gate();
         pending_outcomes.push_back(outcome);
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_outcome(rsp_word_type got);
         rsp_word_type want;
         if (pending_outcomes.size() == 0) begin
            $error("result word %h arrived with no event waiting", got);
            errors++;
            return;
         end
         want = pending_outcomes.pop_front();
         checked++;
         compare_field("mode", want.mode, got.mode);
         compare_field("wifi_allowed", want.wifi_allowed, got.wifi_allowed);
         compare_field("sleep_gate_open", want.sleep_gate_open, got.sleep_gate_open);
         compare_field("source_ignored", want.source_ignored, got.source_ignored);
      endfunction
   endclass

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pmm_req_if req_chan();
   pmm_rsp_if rsp_chan();

   mode_tracker tracker;
   int          cycle_count  = 0;
   int          words_sent   = 0;
   int          settings_run = 0;
   bit          hold_request = 1'b0;
   int          hold_left    = 0;
   int          pattern_age  = 0;
   logic [15:0] stall_pattern = 16'hFFFF;

   power_mode_manager dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            tracker.check_outcome(rsp_chan.word);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age == 64) begin
               pattern_age = 0;
               case ($urandom_range(3))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom | $urandom);
                  default: stall_pattern = 16'($urandom);
               endcase
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_event(req_word_type w);
      req_chan.valid <= 1'b1;
      req_chan.word  <= w;
      do @(posedge clock); while (!req_chan.ready);
      tracker.accept_event(w);
      words_sent++;
   endtask

   task automatic pause_sender(int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_outcomes.size() != 0);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      tracker.set_register(index, value);
   endtask

   task automatic choose_settings(int phase);
      logic [31:0]       dim_v, glance_v, off_v;
      logic [6:0]        crit_v, low_v, saver_v;
      logic signed [7:0] tmin_v, tmax_v;
      case (phase)
         1: begin
            dim_v = '0; glance_v = '0; off_v = '0;
            crit_v = '0; low_v = '0; saver_v = '0;
            tmin_v = -8'sd128; tmax_v = 8'sd127;
         end
         2: begin
            dim_v = '1; glance_v = '1; off_v = '1;
            crit_v = 7'(FULL_PERCENT); low_v = 7'(FULL_PERCENT); saver_v = 7'(FULL_PERCENT);
            tmin_v = 8'sd127; tmax_v = -8'sd128;
         end
         3: begin
            dim_v = $urandom_range(1, 60);
            glance_v = $urandom_range(1, 60);
            off_v = $urandom_range(1, 60);
            crit_v = 7'($urandom_range(FULL_PERCENT));
            low_v = 7'($urandom_range(FULL_PERCENT));
            saver_v = 7'($urandom_range(FULL_PERCENT));
            tmin_v = 8'(int'($urandom_range(40)) - 20);
            tmax_v = 8'(int'(tmin_v) + int'($urandom_range(60)));
         end
         4: begin
            dim_v = $urandom; glance_v = $urandom; off_v = $urandom;
            crit_v = 7'($urandom_range(FULL_PERCENT));
            low_v = 7'($urandom_range(FULL_PERCENT));
            saver_v = 7'($urandom_range(FULL_PERCENT));
            tmin_v = 8'($urandom); tmax_v = 8'($urandom);
         end
         5: begin
            dim_v = 32'd1000; glance_v = 32'd500; off_v = 32'd2000;
            crit_v = 7'd20; low_v = 7'd10; saver_v = 7'd50;
            tmin_v = -8'sd10; tmax_v = 8'sd60;
         end
         default: begin
            dim_v = RESET_IDLE_TO_DIM; glance_v = RESET_DIM_TO_GLANCE;
            off_v = RESET_GLANCE_TO_OFF;
            crit_v = RESET_CRITICAL; low_v = RESET_LOW; saver_v = RESET_SAVER;
            tmin_v = RESET_MIN_TEMP; tmax_v = RESET_MAX_TEMP;
         end
      endcase
      write_register(REG_IDLE_TO_DIM, dim_v);
      write_register(REG_DIM_TO_GLANCE, glance_v);
      write_register(REG_GLANCE_TO_OFF, off_v);
      write_register(REG_CRITICAL, {25'b0, crit_v});
      write_register(REG_LOW, {25'b0, low_v});
      write_register(REG_SAVER, {25'b0, saver_v});
      write_register(REG_MIN_TEMP, {24'b0, tmin_v});
      write_register(REG_MAX_TEMP, {24'b0, tmax_v});
      settings_run++;
   endtask

   function automatic req_word_type blank_event(logic [2:0] func, logic [31:0] now);
      req_word_type w;
      w        = '0;
      w.func   = func;
      w.now_ms = now;
      return w;
   endfunction

   function automatic req_word_type battery_event(logic valid, logic signed [7:0] temp,
                                                  logic charging, logic vbus,
                                                  logic signed [7:0] percent, logic high);
      req_word_type w;
      w                    = blank_event(FUNC_BATTERY, 32'd100);
      w.report_valid       = valid;
      w.report_temperature = temp;
      w.report_charging    = charging;
      w.report_vbus        = vbus;
      w.report_percent     = percent;
      w.heavy_session      = high;
      return w;
   endfunction

   function automatic req_word_type wake_event(logic [3:0] src, logic [15:0] att,
                                               logic [15:0] succ);
      req_word_type w;
      w                = blank_event(FUNC_WAKE, 32'd200);
      w.wake_source    = src;
      w.wake_attempts  = att;
      w.wake_successes = succ;
      return w;
   endfunction

   function automatic req_word_type random_event();
      req_word_type w;
      logic [95:0]  noise;
      logic [31:0]  mark_ms;
      logic [31:0]  span;
      int           pick;
      int           pct_ref;
      noise = {$urandom, $urandom, $urandom};
      w     = noise[$bits(req_word_type)-1:0];
      if ($urandom_range(99) < 5) return w;
      pick = $urandom_range(99);
      if (pick < 20) w.func = FUNC_ACTIVITY;
      else if (pick < 42) w.func = FUNC_BATTERY;
      else if (pick < 52) w.func = FUNC_WIFI;
      else if (pick < 75) w.func = FUNC_WAKE;
      else if (pick < 95) w.func = FUNC_QUERY;
      else w.func = FUNC_QUERY + 3'($urandom_range(1, 3));

      span = tracker.dim_ms + tracker.glance_ms + tracker.off_ms;
      case ($urandom_range(3))
         0: mark_ms = '0;
         1: mark_ms = tracker.dim_ms;
         2: mark_ms = tracker.dim_ms + tracker.glance_ms;
         default: mark_ms = span;
      endcase
      case ($urandom_range(3))
         0: w.now_ms = tracker.last_activity + mark_ms + $urandom_range(4) - 2;
         1: w.now_ms = tracker.last_activity + $urandom_range(span, 0);
         2: w.now_ms = tracker.last_activity + $urandom_range(50);
         default: ;
      endcase

      w.report_valid    = ($urandom_range(3) != 0);
      w.report_charging = ($urandom_range(4) == 0);
      w.report_vbus     = ($urandom_range(4) == 0);
      case ($urandom_range(3))
         0: w.report_temperature = 8'(int'(tracker.temp_min) + int'($urandom_range(4)) - 2);
         1: w.report_temperature = 8'(int'(tracker.temp_max) + int'($urandom_range(4)) - 2);
         2: w.report_temperature = 8'($urandom_range(40));
         default: ;
      endcase
      case ($urandom_range(4))
         0: pct_ref = tracker.critical_pct;
         1: pct_ref = tracker.low_pct;
         2: pct_ref = tracker.saver_pct;
         default: pct_ref = FULL_PERCENT;
      endcase
      if ($urandom_range(9) < 7) begin
         w.report_percent = 8'(pct_ref + int'($urandom_range(4)) - 2);
      end

      pick = $urandom_range(9);
      if (pick < 7) w.wake_source = 4'($urandom_range(REQUIRED_SOURCES - 1));
      else if (pick < 9) w.wake_source = 4'($urandom_range(SOURCES - 1, REQUIRED_SOURCES));
      if ($urandom_range(9) < 6) begin
         w.wake_attempts = 16'($urandom_range(REQUIRED_ATTEMPTS + 10, REQUIRED_ATTEMPTS - 2));
      end
      pick = $urandom_range(99);
      if (pick < 70) w.wake_successes = w.wake_attempts;
      else if (pick < 85) w.wake_successes = w.wake_attempts + 16'($urandom_range(3)) - 16'd1;
      return w;
   endfunction

   task automatic run_random(int count);
      int sent;
      int burst;
      int gap;
      int i;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (i = 0; i < burst && sent < count; i++) begin
            send_event(random_event());
            sent++;
            if (sent == count / 3) hold_request = 1'b1;
            if (sent == (2 * count) / 3) wait_drained();
         end
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) pause_sender(gap);
      end
   endtask

   initial begin
      int phase;
      tracker = new();
      req_chan.valid = 1'b0;
      req_chan.word  = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_event(blank_event(FUNC_QUERY, 32'd0));
      send_event(blank_event(FUNC_QUERY + 3'd1, 32'd29999));
      send_event(blank_event(FUNC_QUERY + 3'd2, 32'd30000));
      send_event(blank_event(FUNC_QUERY, 32'd40000));
      send_event(blank_event(FUNC_QUERY, 32'd60000));
      send_event(blank_event(FUNC_QUERY, 32'hFFFF_FFFF));
      send_event(blank_event(FUNC_ACTIVITY, 32'hFFFF_FFF0));
      send_event(blank_event(FUNC_QUERY, 32'd5));
      send_event(battery_event(1'b0, 8'sd127, 1'b1, 1'b1, -8'sd128, 1'b1));
      send_event(battery_event(1'b1, 8'sd46, 1'b0, 1'b0, 8'sd50, 1'b1));
      send_event(battery_event(1'b1, -8'sd1, 1'b0, 1'b0, 8'sd50, 1'b0));
      send_event(battery_event(1'b1, 8'sd0, 1'b1, 1'b0, 8'sd3, 1'b1));
      send_event(battery_event(1'b1, 8'sd45, 1'b0, 1'b1, 8'sd50, 1'b1));
      send_event(battery_event(1'b1, 8'sd20, 1'b0, 1'b0, -8'sd128, 1'b1));
      send_event(battery_event(1'b1, 8'sd20, 1'b0, 1'b0, 8'sd5, 1'b0));
      send_event(battery_event(1'b1, 8'sd20, 1'b0, 1'b0, 8'sd15, 1'b1));
      send_event(battery_event(1'b1, 8'sd20, 1'b0, 1'b0, 8'sd30, 1'b1));
      send_event(battery_event(1'b1, 8'sd20, 1'b0, 1'b0, 8'sd127, 1'b1));
      send_event(wake_event(4'd15, 16'hFFFF, 16'hFFFF));
      send_event(wake_event(4'd0, 16'd100, 16'hFFFF));
      send_event(wake_event(4'd1, 16'd100, 16'd100));
      send_event(wake_event(4'd2, 16'hFFFF, 16'hFFFF));
      send_event(blank_event(FUNC_WIFI, 32'd300) | req_word_type'(0));
      begin
         req_word_type w;
         w = blank_event(FUNC_WIFI, 32'd300);
         w.wifi_active = 1'b1;
         send_event(w);
      end
      send_event(blank_event(FUNC_WIFI, 32'd400));
      begin
         req_word_type w;
         w = blank_event(FUNC_QUERY + 3'd3, 32'd500);
         w.heavy_session = 1'b1;
         send_event(w);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clock);
            choose_settings(phase);
         end
         run_random(PHASE_WORDS);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d events and checked %0d result words across %0d register settings,",
               words_sent, tracker.checked, settings_run + 1);
      $display("including zero and all-ones timers and inverted temperature limits.");
      if (tracker.errors == 0 && tracker.pending_outcomes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pmm_pkg.sv
rtl/pmm_req_if.sv
rtl/pmm_rsp_if.sv
rtl/pmm_csr.sv
rtl/pmm_state.sv
rtl/pmm_eval.sv
rtl/power_mode_manager.sv
tb/sv/testbench.sv
